[rtl/sha256_stream_hasher_macros.svh]
// assertion macros for the sha256 stream hasher checker
// no dependencies
`ifndef SHA256_STREAM_HASHER_MACROS_SVH
`define SHA256_STREAM_HASHER_MACROS_SVH
// property p holds on every clock edge outside reset
`define SHA_ASSERT(label, clk, rst_n, p) \
    label: assert property (@(posedge clk) disable iff (!rst_n) p) else $error("%m failed");
// property p also holds while reset is asserted
`define SHA_ASSERT_ALWAYS(label, clk, p) \
    label: assert property (@(posedge clk) p) else $error("%m failed");
`endif

[rtl/sha_pkg.sv]
// shared constants and round functions for the sha256 stream hasher
// no dependencies
`timescale 1ns / 1ps
package sha_pkg;
    localparam int BlockBytes = 64;
    localparam int LenPos = 56;
    localparam int Rounds = 64;
    localparam logic [7:0] PadByte = 8'h80;

    localparam logic [31:0] InitH [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

    localparam logic [31:0] RoundK [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b,
        32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01,
        32'h243185be, 32'h550c7dc3, 32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7,
        32'hc19bf174, 32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da, 32'h983e5152,
        32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
        32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc,
        32'h53380d13, 32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3, 32'hd192e819,
        32'hd6990624, 32'hf40e3585, 32'h106aa070, 32'h19a4c116, 32'h1e376c08,
        32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f,
        32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

    typedef logic [31:0] word_t;

    // control from the sequencer to the compression core
    typedef struct packed {
        logic       start;
        logic       reinit;
    } core_ctl_t;

    function automatic word_t rotr(input word_t x, input int n);
        rotr = (x >> n) | (x << (32 - n));
    endfunction

    function automatic word_t ssig0(input word_t x);
        ssig0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic word_t ssig1(input word_t x);
        ssig1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

    function automatic word_t bsig0(input word_t x);
        bsig0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
    endfunction

    function automatic word_t bsig1(input word_t x);
        bsig1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
    endfunction
endpackage

[rtl/sha_core.sv]
// compression core: block words in a memory, 64 rounds, feed-forward of the chaining words
// depends on sha_pkg
`timescale 1ns / 1ps
module sha_core (
    input  logic               clk,
    input  logic               rst_n,
    input  sha_pkg::core_ctl_t ctl,
    // block word write port from the sequencer
    input  logic               wr_en,
    input  logic [3:0]         wr_addr,
    input  sha_pkg::word_t     wr_data,
    output logic               busy,
    output sha_pkg::word_t     hash_out [8]
);
    import sha_pkg::*;

    typedef enum logic [1:0] {S_IDLE, S_PRIME, S_ROUND, S_FOLD} state_t;

    // schedule window memory: 16 words, the rolling w[t mod 16]
    word_t w_mem [16];
    word_t rd_a_reg, rd_b_reg, rd_c_reg;   // w[t-15], w[t-7], w[t-2] slots
    word_t w16_reg;                         // w[t-16] slot, or w[t] itself below 16; prime reads w[0]

    state_t      state_reg;
    logic [6:0]  t_reg;
    word_t       h_reg [8];
    word_t       v_reg [8];
    word_t       w_cur;
    logic [3:0]  slot;
    logic [3:0]  ra, rb, rc, rd;

    assign busy = (state_reg != S_IDLE);
    assign hash_out = h_reg;
    assign slot = t_reg[3:0];

    // reads for the word used at round t+1
    assign ra = slot + 4'd2;   // (t+1)-15
    assign rb = slot + 4'd10;  // (t+1)-7
    assign rc = slot + 4'd15;  // (t+1)-2
    assign rd = slot + 4'd1;   // (t+1)-16, or w[t+1] itself below 16

    // current round word: raw for t<16, expanded otherwise
    always_comb
    begin
        if (t_reg < 7'd16)
            w_cur = w16_reg;
        else
            w_cur = ssig1(rd_c_reg) + rd_b_reg + ssig0(rd_a_reg) + w16_reg;
    end

    // rc points at w[t-1], written at the end of the previous round, so the read sees it
    word_t c_fwd;
    always_ff @(posedge clk)
    begin
        if (wr_en && !busy)
            w_mem[wr_addr] <= wr_data;
        else if (state_reg == S_ROUND)
            w_mem[slot] <= w_cur;
        rd_a_reg <= w_mem[ra];
        rd_b_reg <= w_mem[rb];
        c_fwd    <= w_mem[rc];
        w16_reg  <= (state_reg == S_ROUND) ? w_mem[rd] : w_mem[4'd0];
    end
    assign rd_c_reg = c_fwd;

    word_t x1, x2;
    always_comb
    begin
        x1 = v_reg[7] + bsig1(v_reg[4]) + ((v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]))
             + RoundK[t_reg[5:0]] + w_cur;
        x2 = bsig0(v_reg[0]) + ((v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2])
             ^ (v_reg[1] & v_reg[2]));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            t_reg <= '0;
            for (int i = 0; i < 8; i++)
            begin
                h_reg[i] <= InitH[i];
                v_reg[i] <= '0;
            end
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (ctl.reinit)
                        for (int i = 0; i < 8; i++)
                            h_reg[i] <= InitH[i];
                    if (ctl.start)
                    begin
                        state_reg <= S_PRIME;
                        t_reg <= '0;
                    end
                end
                S_PRIME:
                begin
                    v_reg <= h_reg;
                    state_reg <= S_ROUND;
                end
                S_ROUND:
                begin
                    v_reg[7] <= v_reg[6];
                    v_reg[6] <= v_reg[5];
                    v_reg[5] <= v_reg[4];
                    v_reg[4] <= v_reg[3] + x1;
                    v_reg[3] <= v_reg[2];
                    v_reg[2] <= v_reg[1];
                    v_reg[1] <= v_reg[0];
                    v_reg[0] <= x1 + x2;
                    t_reg <= t_reg + 7'd1;
                    if (t_reg == 7'(Rounds - 1))
                        state_reg <= S_FOLD;
                end
                S_FOLD:
                begin
                    for (int i = 0; i < 8; i++)
                        h_reg[i] <= h_reg[i] + v_reg[i];
                    state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end
endmodule

[rtl/sha256_stream_hasher.sv]
// streaming sha-256 hasher top level: byte packing, padding sequencer, digest output
// depends on sha_pkg and sha_core
//
// usage:
//  - in channel (in_valid/in_ready, op, data_byte): op 0 absorbs one message
//    byte, op 1 finishes the message and requests the digest
//  - out channel (out_valid/out_ready, digest_word, word_index, last): eight
//    words, index 0 first, last set on index 7
//  - bytes are taken while in_ready is high; after every 64th byte in_ready
//    stays low for the start, load, 64 rounds and fold on the round unit
//  - finish: padding is written one word per cycle, then compressed, twice
//    when the padding needs a second block; the first word is valid once
//    the last compression is done, then the eight words go one per
//    accepted out request
//  - the round count over the schedule memory sets the throughput, since no
//    byte is taken while a block is being compressed
//  - reset loads the initial hash values, empties the block and length
//  - a stalled receiver holds the current digest word; no new request is
//    taken until all eight words are delivered
`timescale 1ns / 1ps
module sha256_stream_hasher (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        op,
    input  logic [7:0]  data_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] digest_word,
    output logic [2:0]  word_index,
    output logic        last
);
    import sha_pkg::*;

    typedef enum logic [2:0] {S_ABSORB, S_WAITC, S_PAD, S_WAITF, S_EMIT} state_t;

    state_t      state_reg;
    logic [5:0]  fill_reg;
    logic [63:0] len_reg;
    logic [23:0] pack_reg;      // earlier bytes of the current word
    logic [3:0]  pad_w_reg;     // word slot being padded
    logic        second_reg;    // padding needs a second block
    logic [2:0]  idx_reg;
    logic        start_q_reg;
    core_ctl_t   ctl;
    logic        wr_en;
    logic [3:0]  wr_addr;
    word_t       wr_data;
    logic        busy;
    word_t       hash_out [8];
    word_t       pad_word;
    word_t       part_word;
    logic        in_acc;

    sha_core u_core (
        .clk(clk), .rst_n(rst_n), .ctl(ctl), .wr_en(wr_en), .wr_addr(wr_addr),
        .wr_data(wr_data), .busy(busy), .hash_out(hash_out));

    assign in_acc = in_valid && in_ready;
    assign in_ready = (state_reg == S_ABSORB) && !busy && !start_q_reg;
    assign out_valid = (state_reg == S_EMIT);
    assign digest_word = hash_out[idx_reg];
    assign word_index = idx_reg;
    assign last = (idx_reg == 3'd7);

    // padding word for slot pad_w_reg: partial data, 0x80, zeros, length
    always_comb
    begin
        case (fill_reg[1:0])
            2'd1: part_word = {pack_reg[7:0], 24'h000000};
            2'd2: part_word = {pack_reg[15:0], 16'h0000};
            2'd3: part_word = {pack_reg[23:0], 8'h00};
            default: part_word = '0;
        endcase
        pad_word = '0;
        if (!second_reg && pad_w_reg == fill_reg[5:2])
        begin
            pad_word = part_word;
            pad_word[31 - 8*fill_reg[1:0] -: 8] = PadByte;
        end
        if (pad_w_reg == 4'd14 && (second_reg || fill_reg < 6'(LenPos)))
            pad_word = len_reg[63:32];
        if (pad_w_reg == 4'd15 && (second_reg || fill_reg < 6'(LenPos)))
            pad_word = len_reg[31:0];
    end

    always_comb
    begin
        wr_en = 1'b0;
        wr_addr = fill_reg[5:2];
        wr_data = {pack_reg, data_byte};
        if (in_acc && !op && fill_reg[1:0] == 2'd3)
            wr_en = 1'b1;
        if (state_reg == S_PAD)
        begin
            // full data words below the partial one are already in place
            wr_en = second_reg || (pad_w_reg >= fill_reg[5:2]);
            wr_addr = pad_w_reg;
            wr_data = pad_word;
        end
        ctl.start = start_q_reg;
        ctl.reinit = (state_reg == S_EMIT) && out_ready && last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_ABSORB;
            fill_reg <= '0;
            len_reg <= '0;
            pack_reg <= '0;
            pad_w_reg <= '0;
            second_reg <= 1'b0;
            idx_reg <= '0;
            start_q_reg <= 1'b0;
        end
        else
        begin
            start_q_reg <= 1'b0;
            case (state_reg)
                S_ABSORB:
                begin
                    if (in_acc && !op)
                    begin
                        fill_reg <= fill_reg + 6'd1;
                        pack_reg <= {pack_reg[15:0], data_byte};
                        if (fill_reg == 6'd63)
                        begin
                            len_reg <= len_reg + 64'd512;
                            start_q_reg <= 1'b1;
                        end
                    end
                    else if (in_acc)
                    begin
                        len_reg <= len_reg + {55'd0, fill_reg, 3'd0};
                        pad_w_reg <= '0;
                        second_reg <= 1'b0;
                        state_reg <= S_PAD;
                    end
                end
                S_PAD:
                begin
                    pad_w_reg <= pad_w_reg + 4'd1;
                    if (pad_w_reg == 4'd15)
                    begin
                        start_q_reg <= 1'b1;
                        state_reg <= S_WAITF;
                    end
                end
                S_WAITF:
                begin
                    if (!busy && !start_q_reg)
                    begin
                        if (!second_reg && fill_reg >= 6'(LenPos))
                        begin
                            second_reg <= 1'b1;
                            pad_w_reg <= '0;
                            state_reg <= S_PAD;
                        end
                        else
                        begin
                            idx_reg <= '0;
                            state_reg <= S_EMIT;
                        end
                    end
                end
                S_EMIT:
                begin
                    if (out_ready)
                    begin
                        idx_reg <= idx_reg + 3'd1;
                        if (last)
                        begin
                            fill_reg <= '0;
                            len_reg <= '0;
                            state_reg <= S_ABSORB;
                        end
                    end
                end
                default: state_reg <= S_ABSORB;
            endcase
        end
    end
endmodule

[rtl/sha_checker.sv]
// port-level checker for the sha256 stream hasher, bound to the top level
// depends on sha256_stream_hasher_macros.svh
`timescale 1ns / 1ps
`include "sha256_stream_hasher_macros.svh"
module sha_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [2:0]  word_index,
    input logic        last,
    input logic [31:0] digest_word
);
    `SHA_ASSERT(a_no_overlap, clk, rst_n, !(in_ready && out_valid))
    `SHA_ASSERT(a_in_hold, clk, rst_n, (in_valid && !in_ready) |=> in_valid)
    `SHA_ASSERT(a_last_idx, clk, rst_n, out_valid |-> (last == (word_index == 3'd7)))
    `SHA_ASSERT(a_hold, clk, rst_n, (out_valid && !out_ready) |=>
        (out_valid && $stable(digest_word) && $stable(word_index)))
    `SHA_ASSERT(a_next_idx, clk, rst_n, (out_valid && out_ready && !last) |=>
        (out_valid && word_index == $past(word_index) + 3'd1))
endmodule

bind sha256_stream_hasher sha_checker u_sha_checker (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready), .word_index(word_index),
    .last(last), .digest_word(digest_word));
